// ===== rtl/core/ordered_timer_queue_core_defines.svh =====
// ----------------------------------------------------------------------------
// ordered_timer_queue_core_defines.svh
// Assertion macros used by the timer queue port checker.
// ----------------------------------------------------------------------------
`ifndef ORDERED_TIMER_QUEUE_CORE_DEFINES_SVH
`define ORDERED_TIMER_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define OTQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define OTQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/otq_pkg.sv =====
// ----------------------------------------------------------------------------
// otq_pkg
// Types, constants and helpers for the ordered timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package otq_pkg;

   localparam int DEPTH  = 16;
   localparam int TIME_W = 48;
   localparam int ID_W   = 32;
   localparam int DLY_W  = 32;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SLP_W  = TIME_W + 1;

   localparam logic [SLP_W-1:0] SLEEP_NONE = {SLP_W{1'b1}};

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_DEL   = 2'd1;
   localparam logic [1:0] CMD_CHECK = 2'd2;

   typedef enum logic [1:0] {
      ST_DONE,
      ST_FULL,
      ST_NOT_FOUND,
      ST_NONE_DUE
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_INSERT,
      OP_REMOVE
   } op_code_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_SCAN,
      S_APPLY,
      S_FIN
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [TIME_W-1:0] expire;
      logic [ID_W-1:0]   id;
   } entry_type;

   // broadcast to every cell: what to do and the pair it concerns
   typedef struct packed {
      op_code_type       code;
      logic [TIME_W-1:0] key_expire;
      logic [ID_W-1:0]   key_id;
   } op_type;

   localparam entry_type NULL_ENTRY = '{valid: 1'b0, expire: '0, id: '0};

   function automatic logic pair_less(input logic [TIME_W-1:0] ea,
                                      input logic [ID_W-1:0]   ia,
                                      input logic [TIME_W-1:0] eb,
                                      input logic [ID_W-1:0]   ib);
      logic less;
      less = (ea != eb) ? (ea < eb) : (ia < ib);
      return less;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ordered_timer_queue_core.sv =====
// Sequence: after a request transfer the sum, scan, apply and finish states run in
// order; the result is registered on leaving finish, which waits while the previous result is still held.
// Items: one at a time; a new request is taken only in idle, after the
// single-item control sequence around the cell chain (one shift of the chain per item).
// Reset: synchronous, active high; empties the chain, zeroes the id counter
// and the pending count, and drops any held result. No clearing pass.
// ----------------------------------------------------------------------------
// ordered_timer_queue_core
// Sorted timer queue: add, delete and fire-earliest over a chain of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_timer_queue_core (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire  [1:0]                    req_cmd,
   input  wire  [otq_pkg::TIME_W-1:0]    req_now_ms,
   input  wire  [otq_pkg::DLY_W-1:0]     req_delay_ms,
   input  wire  [otq_pkg::TIME_W-1:0]    req_key_expire,
   input  wire  [otq_pkg::ID_W-1:0]      req_key_id,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [otq_pkg::ID_W-1:0]      rsp_timer_id,
   output logic [otq_pkg::TIME_W-1:0]    rsp_expire_time,
   output logic signed [otq_pkg::SLP_W-1:0] rsp_sleep_ms,
   output logic [otq_pkg::CNT_W-1:0]     rsp_pending_count
);
   import otq_pkg::*;

   state_type state_ff, state_in;

   logic [1:0]        cmd_ff, cmd_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [DLY_W-1:0]  delay_ff, delay_in;
   op_type            op_ff, op_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ID_W-1:0]   next_id_ff, next_id_in;
   status_type        status_ff, status_in;
   logic [ID_W-1:0]   rid_ff, rid_in;
   logic [TIME_W-1:0] rexp_ff, rexp_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [TIME_W-1:0] rsp_exp_ff, rsp_exp_in;
   logic [SLP_W-1:0]  rsp_sleep_ff, rsp_sleep_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // state machine outputs
   logic   take_req;
   logic   load_rsp;
   op_type chain_op;

   entry_type        head;
   logic             any_match;
   logic [TIME_W:0]  sum;
   logic [TIME_W-1:0] sum_sat;
   logic [SLP_W-1:0] diff;
   logic             full;

   otq_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .op         (chain_op),
      .head_entry (head),
      .any_match  (any_match)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_SUM;
         S_SUM:   state_in = S_SCAN;
         S_SCAN:  state_in = S_APPLY;
         S_APPLY: state_in = S_FIN;
         S_FIN:   if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // state machine outputs
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      chain_op  = op_ff;
      chain_op.code = OP_NONE;
      case (state_ff)
         S_IDLE:  req_ready = 1'b1;
         S_APPLY: chain_op.code = op_ff.code;
         S_FIN:   load_rsp = !rsp_valid_ff || rsp_ready;
         default: req_ready = 1'b0;
      endcase
   end

   assign take_req = req_valid && req_ready;

   always_comb begin
      sum     = {1'b0, now_ff} + {{(TIME_W + 1 - DLY_W){1'b0}}, delay_ff};
      sum_sat = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
      full    = (count_ff == CNT_W'(DEPTH));
      // earliest expiry minus now; top bit set means already past
      diff    = {1'b0, head.expire} - {1'b0, now_ff};
   end

   // datapath
   always_comb begin
      cmd_in     = cmd_ff;
      now_in     = now_ff;
      delay_in   = delay_ff;
      op_in      = op_ff;
      count_in   = count_ff;
      next_id_in = next_id_ff;
      status_in  = status_ff;
      rid_in     = rid_ff;
      rexp_in    = rexp_ff;

      if (take_req) begin
         cmd_in        = req_cmd;
         now_in        = req_now_ms;
         delay_in      = req_delay_ms;
         op_in.code    = OP_NONE;
         op_in.key_expire = req_key_expire;
         op_in.key_id  = req_key_id;
      end

      case (state_ff)
         S_SUM: begin
            if (cmd_ff == CMD_ADD) begin
               op_in.key_expire = sum_sat;
               op_in.key_id     = next_id_ff;
            end
         end
         S_SCAN: begin
            op_in.code = OP_NONE;
            status_in  = ST_NONE_DUE;
            rid_in     = '0;
            rexp_in    = '0;
            case (cmd_ff)
               CMD_ADD: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     status_in  = ST_DONE;
                     rid_in     = op_ff.key_id;
                     rexp_in    = op_ff.key_expire;
                     next_id_in = next_id_ff + ID_W'(1);
                     // an identical pair already held is not stored twice
                     if (!any_match) begin
                        op_in.code = OP_INSERT;
                        count_in   = count_ff + CNT_W'(1);
                     end
                  end
               end
               CMD_DEL: begin
                  if (any_match) begin
                     status_in  = ST_DONE;
                     op_in.code = OP_REMOVE;
                     count_in   = count_ff - CNT_W'(1);
                  end else begin
                     status_in = ST_NOT_FOUND;
                  end
               end
               CMD_CHECK: begin
                  if (head.valid && (head.expire < now_ff)) begin
                     status_in        = ST_DONE;
                     rid_in           = head.id;
                     rexp_in          = head.expire;
                     op_in.code       = OP_REMOVE;
                     op_in.key_expire = head.expire;
                     op_in.key_id     = head.id;
                     count_in         = count_ff - CNT_W'(1);
                  end
               end
               default: begin
                  status_in = ST_NONE_DUE;
               end
            endcase
         end
         default: begin
            op_in = op_in;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_exp_in    = rsp_exp_ff;
      rsp_sleep_in  = rsp_sleep_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_id_in     = rid_ff;
         rsp_exp_in    = rexp_ff;
         rsp_count_in  = count_ff;
         if (!head.valid) begin
            rsp_sleep_in = SLEEP_NONE;
         end else if (diff[SLP_W-1]) begin
            rsp_sleep_in = '0;
         end else begin
            rsp_sleep_in = diff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         next_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         op_ff.code   <= OP_NONE;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff           <= cmd_in;
      now_ff           <= now_in;
      delay_ff         <= delay_in;
      status_ff        <= status_in;
      rid_ff           <= rid_in;
      rexp_ff          <= rexp_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_id_ff        <= rsp_id_in;
      rsp_exp_ff       <= rsp_exp_in;
      rsp_sleep_ff     <= rsp_sleep_in;
      rsp_count_ff     <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_timer_id      = rsp_id_ff;
   assign rsp_expire_time   = rsp_exp_ff;
   assign rsp_sleep_ms      = $signed(rsp_sleep_ff);
   assign rsp_pending_count = rsp_count_ff;

endmodule

`default_nettype wire

// ===== rtl/core/otq_cell.sv =====
// ----------------------------------------------------------------------------
// otq_cell
// One slot of the sorted chain: holds a timer, inserts or shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module otq_cell (
   input  wire                 clock,
   input  wire                 reset,
   input  otq_pkg::op_type     op,
   input  otq_pkg::entry_type  left_entry,
   input  otq_pkg::entry_type  right_entry,
   input  wire                 left_ins,
   output otq_pkg::entry_type  entry,
   output logic                ins,
   output logic                match
);
   import otq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      geq;

   always_comb begin
      match = entry_ff.valid && (entry_ff.expire == op.key_expire)
              && (entry_ff.id == op.key_id);
      // chain is sorted, so ins is low for a prefix and high after it
      ins = !entry_ff.valid
            || pair_less(op.key_expire, op.key_id, entry_ff.expire, entry_ff.id);
      geq = entry_ff.valid
            && !pair_less(entry_ff.expire, entry_ff.id, op.key_expire, op.key_id);
      entry_in = entry_ff;
      case (op.code)
         OP_INSERT: begin
            if (ins) begin
               if (left_ins) begin
                  entry_in = left_entry;
               end else begin
                  entry_in = '{valid: 1'b1, expire: op.key_expire, id: op.key_id};
               end
            end
         end
         OP_REMOVE: begin
            if (geq) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ===== rtl/core/otq_chain.sv =====
// ----------------------------------------------------------------------------
// otq_chain
// Row of timer cells kept sorted by expiry, then id, packed to the head.
// ----------------------------------------------------------------------------
`default_nettype none

module otq_chain (
   input  wire                 clock,
   input  wire                 reset,
   input  otq_pkg::op_type     op,
   output otq_pkg::entry_type  head_entry,
   output logic                any_match
);
   import otq_pkg::*;

   entry_type        entries [DEPTH];
   logic [DEPTH-1:0] ins;
   logic [DEPTH-1:0] match;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      logic      left_i;

      if (i == 0) begin : g_first
         assign left_e = NULL_ENTRY;
         assign left_i = 1'b0;
      end else begin : g_mid
         assign left_e = entries[i-1];
         assign left_i = ins[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_e = NULL_ENTRY;
      end else begin : g_body
         assign right_e = entries[i+1];
      end

      otq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .left_entry  (left_e),
         .right_entry (right_e),
         .left_ins    (left_i),
         .entry       (entries[i]),
         .ins         (ins[i]),
         .match       (match[i])
      );
   end

   assign head_entry = entries[0];
   assign any_match  = |match;

endmodule

`default_nettype wire

// ===== rtl/core/otq_port_checker.sv =====
// ----------------------------------------------------------------------------
// otq_port_checker
// Port-level checks for the ordered timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_timer_queue_core_defines.svh"

module otq_port_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_valid,
   input wire                           req_ready,
   input wire                           rsp_valid,
   input wire                           rsp_ready,
   input wire [1:0]                     rsp_status,
   input wire [otq_pkg::ID_W-1:0]       rsp_timer_id,
   input wire [otq_pkg::TIME_W-1:0]     rsp_expire_time,
   input wire [otq_pkg::SLP_W-1:0]      rsp_sleep_ms,
   input wire [otq_pkg::CNT_W-1:0]      rsp_pending_count
);
   import otq_pkg::*;

   logic                                  req_fire;
   logic                                  rsp_stall;
   logic                                  rsp_empty;
   logic                                  rsp_idle;
   logic                                  rsp_full;
   logic                                  full_ok;
   logic                                  count_ok;
   logic [ID_W+TIME_W+SLP_W+CNT_W+1:0]    rsp_data;

   assign req_fire  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_empty = (rsp_pending_count == CNT_W'(0));
   assign rsp_idle  = (rsp_sleep_ms == SLEEP_NONE);
   assign rsp_full  = (rsp_status == ST_FULL);
   assign full_ok   = (rsp_pending_count == CNT_W'(DEPTH)) && (rsp_timer_id == '0);
   assign count_ok  = (rsp_pending_count <= CNT_W'(DEPTH));
   assign rsp_data  = {rsp_status, rsp_timer_id, rsp_expire_time, rsp_sleep_ms,
                       rsp_pending_count};

   `OTQ_ASSERT_NEXT(a_one_in_flight, req_fire, !req_ready, "second transfer taken while busy")
   `OTQ_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")
   `OTQ_ASSERT_SAME(a_empty_sleep, rsp_valid, rsp_empty == rsp_idle, "sleep and count disagree")
   `OTQ_ASSERT_SAME(a_full_status, rsp_valid && rsp_full, full_ok, "full reported below depth")
   `OTQ_ASSERT_SAME(a_count_range, rsp_valid, count_ok, "pending count above depth")

endmodule

bind ordered_timer_queue_core otq_port_checker u_otq_port_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_timer_id      (rsp_timer_id),
   .rsp_expire_time   (rsp_expire_time),
   .rsp_sleep_ms      (rsp_sleep_ms),
   .rsp_pending_count (rsp_pending_count)
);

`default_nettype wire
